[src/json_key_value_extractor_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the JSON key/value extractor
// Shared wrappers so that every check is clocked and reset-gated alike.
// ---------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH
`define JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JKVE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JKVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/jkve_pkg.sv]
// ---------------------------------------------------------------------------
// jkve_pkg
// Types and constants of the JSON key/value extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package jkve_pkg;

    // Payload of one input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_object;
    } text_item_t;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } result_kind_t;

    // Payload of one output transaction.
    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   value_char;
        logic         bool_value;
        logic         final_res;
    } result_item_t;

    typedef enum logic [6:0] {
        PH_SEARCH       = 7'b0000001,
        PH_IN_STRING    = 7'b0000010,
        PH_AFTER_STRING = 7'b0000100,
        PH_BEFORE_VALUE = 7'b0001000,
        PH_VALUE_STR    = 7'b0010000,
        PH_LIT_TRUE     = 7'b0100000,
        PH_LIT_FALSE    = 7'b1000000
    } phase_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_KIND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 3'd4;

    localparam int CFG_DATA_W  = 64;
    localparam int KEY_LEN_W   = 5;
    localparam int CAP_W       = 9;
    localparam int KEY_SLOTS   = 16;
    localparam int KEY_SEL_W   = 4;
    localparam int CMP_W       = 6;
    localparam int LIT_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;

    localparam logic [LIT_IDX_W-1:0] TRUE_LEN  = 3'd4;
    localparam logic [LIT_IDX_W-1:0] FALSE_LEN = 3'd5;

    // Characters of the literal "true".
    function automatic logic [7:0] true_char(input logic [LIT_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the literal "false".
    function automatic logic [7:0] false_char(input logic [LIT_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_NEWLINE) || (b == CH_TAB);
    endfunction

endpackage

`default_nettype wire

[src/json_key_value_extractor.sv]
// ---------------------------------------------------------------------------
// json_key_value_extractor
// Streams the bytes of a JSON object and returns the value of one configured
// top-level key, either as unescaped string characters or as a boolean.
// ---------------------------------------------------------------------------
// The block takes one byte of a JSON object per cycle on the text channel
// while text_stall is low, with end_of_object high on the last byte. An
// accepted byte waits in an input stage register until the result queue has
// room. In the cycle that it leaves the stage, the parser state is updated
// and its results (at most one value character and one status) are pushed
// into a four-entry result queue. The queue head drives the result channel,
// so a result is presented once its byte has left the input stage and its
// results have been registered into the queue. A byte leaves the input stage
// when the queue has room for two results after this cycle's pop, so the input
// runs at one byte per cycle as long as the result side takes one
// transaction per cycle; the result port, delivering one transaction per
// cycle, sets the sustained rate when bytes cause more results than that.
// Every object ends in exactly one status transaction with final_res high
// (found or not found). Configuration registers are written through the cfg
// channel, which is always ready, and should only be written while no byte
// is in flight and the result queue is empty.
`default_nettype none

`include "json_key_value_extractor_macros.svh"

module json_key_value_extractor #(
    parameter int MAX_KEY_BYTES = 16,
    parameter int DEPTH_BITS    = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  text_valid,
    output logic                                       text_stall,
    input  wire jkve_pkg::text_item_t                  text_item,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output jkve_pkg::result_item_t                     result_item,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [jkve_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [jkve_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import jkve_pkg::*;

    // Wide enough to hold MAX_KEY_BYTES itself.
    localparam int KIDX_W = $clog2(MAX_KEY_BYTES + 1);

    // -----------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // -----------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic                  value_kind_reg;
    logic [CAP_W-1:0]      out_capacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg      <= '0;
            key_high_reg     <= '0;
            key_length_reg   <= '0;
            value_kind_reg   <= 1'b0;
            out_capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:      key_low_reg      <= cfg_data;
                CFG_KEY_HIGH:     key_high_reg     <= cfg_data;
                CFG_KEY_LENGTH:   key_length_reg   <= cfg_data[KEY_LEN_W-1:0];
                CFG_VALUE_KIND:   value_kind_reg   <= cfg_data[0];
                CFG_OUT_CAPACITY: out_capacity_reg <= cfg_data[CAP_W-1:0];
                default:          ;
            endcase
        end
    end

    // The key as individual bytes, byte zero first.
    logic [7:0] key_bytes [KEY_SLOTS];

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS / 2; i++)
        begin
            key_bytes[i]                 = key_low_reg[i*8 +: 8];
            key_bytes[i + KEY_SLOTS / 2] = key_high_reg[i*8 +: 8];
        end
    end

    // -----------------------------------------------------------------------
    // Input stage and result queue handshakes.
    // -----------------------------------------------------------------------
    logic                stage_valid_reg;
    text_item_t          stage_item_reg;
    result_item_t        queue_reg [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0] queue_count_reg;
    logic [QCOUNT_W-1:0] count_after_pop;
    logic                pop;
    logic                advance;
    logic                text_accept;

    assign pop             = (queue_count_reg != '0) && !result_stall;
    assign count_after_pop = queue_count_reg - QCOUNT_W'(pop);
    // Each byte can push two results, so two free entries are needed.
    assign advance         = stage_valid_reg
                             && (count_after_pop <= QCOUNT_W'(QUEUE_DEPTH - 2));
    assign text_stall      = stage_valid_reg && !advance;
    assign text_accept     = text_valid && !text_stall;

    assign result_valid = (queue_count_reg != '0);
    assign result_item  = queue_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (text_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            stage_item_reg <= text_item;
        end
    end

    // -----------------------------------------------------------------------
    // Parser state.
    // -----------------------------------------------------------------------
    logic [DEPTH_BITS-1:0] depth_reg,        depth_next;
    phase_t                phase_reg,        phase_next;
    logic                  escape_reg,       escape_next;
    logic [KIDX_W-1:0]     key_index_reg,    key_index_next;
    logic                  key_matching_reg, key_matching_next;
    logic [CAP_W-1:0]      emitted_reg,      emitted_next;
    logic [LIT_IDX_W-1:0]  lit_index_reg,    lit_index_next;
    logic                  answered_reg,     answered_next;

    logic [7:0]   b;
    logic         last;
    logic [7:0]   key_byte_sel;
    logic         key_step_ok;
    logic         emit_ok;
    logic         do_search;
    logic         char_valid;
    logic [7:0]   char_value;
    logic         status_valid;
    result_kind_t status_kind;
    logic         status_bool;

    assign b    = stage_item_reg.text_byte;
    assign last = stage_item_reg.end_of_object;

    assign key_byte_sel = key_bytes[KEY_SEL_W'(key_index_reg)];

    // Raw comparison of one string byte against the next key byte.
    assign key_step_ok = key_matching_reg
                         && (CMP_W'(key_index_reg) < CMP_W'(key_length_reg))
                         && (CMP_W'(key_index_reg) < CMP_W'(MAX_KEY_BYTES))
                         && (b == key_byte_sel);

    // Room for one more character: emitted + 1 < capacity.
    assign emit_ok = ({1'b0, emitted_reg} + 1'b1) < {1'b0, out_capacity_reg};

    always_comb
    begin
        depth_next        = depth_reg;
        phase_next        = phase_reg;
        escape_next       = escape_reg;
        key_index_next    = key_index_reg;
        key_matching_next = key_matching_reg;
        emitted_next      = emitted_reg;
        lit_index_next    = lit_index_reg;
        answered_next     = answered_reg;
        do_search         = 1'b0;
        char_valid        = 1'b0;
        char_value        = b;
        status_valid      = 1'b0;
        status_kind       = KIND_NOT_FOUND;
        status_bool       = 1'b0;

        if (!answered_reg)
        begin
            unique case (phase_reg)
                PH_IN_STRING:
                begin
                    if (escape_reg)
                    begin
                        escape_next       = 1'b0;
                        key_index_next    = KIDX_W'(key_index_reg + 1'b1);
                        key_matching_next = key_step_ok;
                        if (!key_step_ok)
                        begin
                            key_index_next = key_index_reg;
                        end
                    end
                    else if (b == CH_QUOTE)
                    begin
                        if (depth_reg == DEPTH_BITS'(1))
                        begin
                            key_matching_next = key_matching_reg
                                && (CMP_W'(key_index_reg) == CMP_W'(key_length_reg));
                            phase_next = PH_AFTER_STRING;
                        end
                        else
                        begin
                            phase_next = PH_SEARCH;
                        end
                    end
                    else
                    begin
                        if (b == CH_BACKSLASH)
                        begin
                            escape_next = 1'b1;
                        end
                        key_matching_next = key_step_ok;
                        if (key_step_ok)
                        begin
                            key_index_next = KIDX_W'(key_index_reg + 1'b1);
                        end
                    end
                end
                PH_AFTER_STRING:
                begin
                    if (!is_space(b))
                    begin
                        if ((b == CH_COLON) && key_matching_reg)
                        begin
                            phase_next = PH_BEFORE_VALUE;
                        end
                        else
                        begin
                            do_search = 1'b1;
                        end
                    end
                end
                PH_BEFORE_VALUE:
                begin
                    if (!is_space(b))
                    begin
                        if (!value_kind_reg)
                        begin
                            if (b == CH_QUOTE)
                            begin
                                phase_next   = PH_VALUE_STR;
                                escape_next  = 1'b0;
                                emitted_next = '0;
                            end
                            else
                            begin
                                status_valid = 1'b1;
                            end
                        end
                        else if (b == CH_T)
                        begin
                            phase_next     = PH_LIT_TRUE;
                            lit_index_next = LIT_IDX_W'(1);
                        end
                        else if (b == CH_F)
                        begin
                            phase_next     = PH_LIT_FALSE;
                            lit_index_next = LIT_IDX_W'(1);
                        end
                        else
                        begin
                            status_valid = 1'b1;
                        end
                    end
                end
                PH_VALUE_STR:
                begin
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        char_valid  = emit_ok;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        status_valid = 1'b1;
                        status_kind  = KIND_FOUND;
                    end
                    else if ((b == CH_BACKSLASH) && !last)
                    begin
                        escape_next = 1'b1;
                    end
                    else
                    begin
                        char_valid = emit_ok;
                    end
                    if (char_valid)
                    begin
                        emitted_next = CAP_W'(emitted_reg + 1'b1);
                    end
                end
                PH_LIT_TRUE:
                begin
                    status_valid = 1'b1;
                    if ((lit_index_reg < TRUE_LEN) && (b == true_char(lit_index_reg)))
                    begin
                        lit_index_next = LIT_IDX_W'(lit_index_reg + 1'b1);
                        status_valid   = (lit_index_next == TRUE_LEN);
                        status_kind    = KIND_FOUND;
                        status_bool    = 1'b1;
                    end
                end
                PH_LIT_FALSE:
                begin
                    status_valid = 1'b1;
                    if ((lit_index_reg < FALSE_LEN) && (b == false_char(lit_index_reg)))
                    begin
                        lit_index_next = LIT_IDX_W'(lit_index_reg + 1'b1);
                        status_valid   = (lit_index_next == FALSE_LEN);
                        status_kind    = KIND_FOUND;
                    end
                end
                default:
                begin
                    do_search = 1'b1;
                end
            endcase

            // Bracket tracking and string opening outside strings.
            if (do_search)
            begin
                phase_next = PH_SEARCH;
                if ((b == CH_LBRACE) || (b == CH_LBRACKET))
                begin
                    depth_next = DEPTH_BITS'(depth_reg + 1'b1);
                end
                else if ((b == CH_RBRACE) || (b == CH_RBRACKET))
                begin
                    depth_next = DEPTH_BITS'(depth_reg - 1'b1);
                end
                else if (b == CH_QUOTE)
                begin
                    phase_next        = PH_IN_STRING;
                    escape_next       = 1'b0;
                    key_index_next    = '0;
                    key_matching_next =
                        (CMP_W'(key_length_reg) <= CMP_W'(MAX_KEY_BYTES));
                end
            end

            if (status_valid)
            begin
                answered_next = 1'b1;
            end
        end

        // The last byte closes the object: give the answer if none yet.
        if (last)
        begin
            if (!answered_next)
            begin
                status_valid = 1'b1;
                status_bool  = 1'b0;
                status_kind  = (phase_next == PH_VALUE_STR) ? KIND_FOUND : KIND_NOT_FOUND;
            end
            depth_next        = '0;
            phase_next        = PH_SEARCH;
            escape_next       = 1'b0;
            key_index_next    = '0;
            key_matching_next = 1'b0;
            emitted_next      = '0;
            lit_index_next    = '0;
            answered_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            phase_reg        <= PH_SEARCH;
            escape_reg       <= 1'b0;
            key_index_reg    <= '0;
            key_matching_reg <= 1'b0;
            emitted_reg      <= '0;
            lit_index_reg    <= '0;
            answered_reg     <= 1'b0;
        end
        else if (advance)
        begin
            depth_reg        <= depth_next;
            phase_reg        <= phase_next;
            escape_reg       <= escape_next;
            key_index_reg    <= key_index_next;
            key_matching_reg <= key_matching_next;
            emitted_reg      <= emitted_next;
            lit_index_reg    <= lit_index_next;
            answered_reg     <= answered_next;
        end
    end

    // -----------------------------------------------------------------------
    // Result queue: entry zero is the head; entries shift down on a pop and
    // new results land just above the surviving ones, character first.
    // -----------------------------------------------------------------------
    result_item_t        char_item;
    result_item_t        status_item;
    result_item_t        first_item;
    logic                push_first;
    logic                push_second;
    logic [QCOUNT_W-1:0] push_count;
    logic [QCOUNT_W-1:0] count_next;

    always_comb
    begin
        char_item.result_kind   = KIND_CHAR;
        char_item.value_char    = char_value;
        char_item.bool_value    = 1'b0;
        char_item.final_res     = 1'b0;
        status_item.result_kind = status_kind;
        status_item.value_char  = 8'h00;
        status_item.bool_value  = status_bool;
        status_item.final_res   = 1'b1;
    end

    assign push_first  = advance && (char_valid || status_valid);
    assign push_second = advance && char_valid && status_valid;
    assign first_item  = char_valid ? char_item : status_item;
    assign push_count  = QCOUNT_W'(push_first) + QCOUNT_W'(push_second);
    assign count_next  = count_after_pop + push_count;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push_first && (count_after_pop == QCOUNT_W'(i)))
            begin
                queue_reg[i] <= first_item;
            end
            else if (push_second && (count_after_pop == QCOUNT_W'(i - 1)))
            begin
                queue_reg[i] <= status_item;
            end
            else if (pop && (i < QUEUE_DEPTH - 1))
            begin
                queue_reg[i] <= queue_reg[(i + 1) % QUEUE_DEPTH];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_count_reg <= '0;
        end
        else
        begin
            queue_count_reg <= count_next;
        end
    end

    // -----------------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------------
    `JKVE_ASSERT_SAME(a_queue_bound, 1'b1,
        queue_count_reg <= QCOUNT_W'(QUEUE_DEPTH), "result queue overflow")
    `JKVE_ASSERT_SAME(a_quiet_after_answer,
        advance && answered_reg && !stage_item_reg.end_of_object,
        push_count == '0, "result produced after the answer was given")
    `JKVE_ASSERT_NEXT(a_clear_on_last, advance && stage_item_reg.end_of_object,
        (phase_reg == PH_SEARCH) && (depth_reg == '0) && !answered_reg,
        "parser state not cleared after the last byte")
    `JKVE_ASSERT_SAME(a_stall_needs_item, text_stall, stage_valid_reg,
        "text channel stalled with an empty input stage")

endmodule

`default_nettype wire

[tb/jkve_scoreboard_pkg.sv]
// ---------------------------------------------------------------------------
// Scoreboard for the JSON key/value extractor
// Follows the parser state byte by byte, queues the results that each
// accepted byte should cause and checks the block's results against them.
// ---------------------------------------------------------------------------
package jkve_scoreboard_pkg;

    import jkve_pkg::*;

    class extract_scoreboard;
        // Copies of the configuration registers.
        logic [127:0] key_bits;
        logic [4:0]   key_len;
        logic         bool_mode;
        logic [8:0]   capacity;

        // Parser state, cleared after the last byte of every object.
        logic [7:0]   depth;
        phase_t       phase;
        bit           escaped;
        int unsigned  key_pos;
        bit           key_alive;
        int unsigned  emitted;
        int unsigned  word_pos;
        bit           answered;

        string        word_true = "true";
        string        word_false = "false";

        result_item_t expected_q[$];
        int unsigned  errors;
        int unsigned  results_checked;
        int unsigned  chars_seen;
        int unsigned  found_seen;
        int unsigned  missing_seen;

        function new();
            key_bits = '0;
            key_len = '0;
            bool_mode = 1'b0;
            capacity = CAP_RESET;
            errors = 0;
            results_checked = 0;
            chars_seen = 0;
            found_seen = 0;
            missing_seen = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            depth = '0;
            phase = PH_SEARCH;
            escaped = 1'b0;
            key_pos = 0;
            key_alive = 1'b0;
            emitted = 0;
            word_pos = 0;
            answered = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KEY_LOW:      key_bits[63:0] = data;
                CFG_KEY_HIGH:     key_bits[127:64] = data;
                CFG_KEY_LENGTH:   key_len = data[KEY_LEN_W-1:0];
                CFG_VALUE_KIND:   bool_mode = data[0];
                CFG_OUT_CAPACITY: capacity = data[CAP_W-1:0];
                default:          ;
            endcase
        endfunction

        function void push_result(result_kind_t kind, logic [7:0] ch, logic bv, logic fin);
            result_item_t r;
            r.result_kind = kind;
            r.value_char = ch;
            r.bool_value = bv;
            r.final_res = fin;
            expected_q.push_back(r);
        endfunction

        function void answer(result_kind_t kind, logic bv);
            push_result(kind, 8'h00, bv, 1'b1);
            answered = 1'b1;
        endfunction

        // The output buffer keeps one place for the terminator.
        function void emit(logic [7:0] ch);
            if (emitted + 1 < capacity) begin
                push_result(KIND_CHAR, ch, 1'b0, 1'b0);
                emitted++;
            end
        endfunction

        function bit blank_byte(logic [7:0] b);
            return (b == CH_SPACE) || (b == CH_NEWLINE) || (b == CH_TAB);
        endfunction

        // Keys are compared raw, so escape bytes take part in the match.
        function void key_step(logic [7:0] b);
            if (key_alive && key_pos < key_len && key_pos < KEY_SLOTS &&
                b == key_bits[key_pos*8 +: 8])
                key_pos++;
            else
                key_alive = 1'b0;
        endfunction

        function void outside_byte(logic [7:0] b);
            phase = PH_SEARCH;
            if (b == CH_LBRACE || b == CH_LBRACKET) begin
                depth++;
            end
            else if (b == CH_RBRACE || b == CH_RBRACKET) begin
                depth--;
            end
            else if (b == CH_QUOTE) begin
                phase = PH_IN_STRING;
                escaped = 1'b0;
                key_pos = 0;
                key_alive = (key_len <= KEY_SLOTS);
            end
        endfunction

        function void note_text(text_item_t item);
            logic [7:0] b;
            bit         last;
            b = item.text_byte;
            last = item.end_of_object;
            if (!answered) begin
                case (phase)
                    PH_IN_STRING:
                        if (escaped) begin
                            escaped = 1'b0;
                            key_step(b);
                        end
                        else if (b == CH_QUOTE) begin
                            if (depth == 8'd1) begin
                                key_alive = key_alive && (key_pos == key_len);
                                phase = PH_AFTER_STRING;
                            end
                            else begin
                                phase = PH_SEARCH;
                            end
                        end
                        else begin
                            if (b == CH_BACKSLASH)
                                escaped = 1'b1;
                            key_step(b);
                        end
                    PH_AFTER_STRING:
                        if (!blank_byte(b)) begin
                            if (b == CH_COLON && key_alive)
                                phase = PH_BEFORE_VALUE;
                            else
                                outside_byte(b);
                        end
                    PH_BEFORE_VALUE:
                        if (!blank_byte(b)) begin
                            if (!bool_mode) begin
                                if (b == CH_QUOTE) begin
                                    phase = PH_VALUE_STR;
                                    escaped = 1'b0;
                                    emitted = 0;
                                end
                                else begin
                                    answer(KIND_NOT_FOUND, 1'b0);
                                end
                            end
                            else if (b == CH_T) begin
                                phase = PH_LIT_TRUE;
                                word_pos = 1;
                            end
                            else if (b == CH_F) begin
                                phase = PH_LIT_FALSE;
                                word_pos = 1;
                            end
                            else begin
                                answer(KIND_NOT_FOUND, 1'b0);
                            end
                        end
                    PH_VALUE_STR:
                        // A backslash on the final byte has nothing to escape and is sent as is.
                        if (escaped) begin
                            escaped = 1'b0;
                            emit(b);
                        end
                        else if (b == CH_QUOTE) begin
                            answer(KIND_FOUND, 1'b0);
                        end
                        else if (b == CH_BACKSLASH && !last) begin
                            escaped = 1'b1;
                        end
                        else begin
                            emit(b);
                        end
                    PH_LIT_TRUE:
                        if (word_pos < word_true.len() && b == word_true[word_pos]) begin
                            word_pos++;
                            if (word_pos == word_true.len())
                                answer(KIND_FOUND, 1'b1);
                        end
                        else begin
                            answer(KIND_NOT_FOUND, 1'b0);
                        end
                    PH_LIT_FALSE:
                        if (word_pos < word_false.len() && b == word_false[word_pos]) begin
                            word_pos++;
                            if (word_pos == word_false.len())
                                answer(KIND_FOUND, 1'b0);
                        end
                        else begin
                            answer(KIND_NOT_FOUND, 1'b0);
                        end
                    default:
                        outside_byte(b);
                endcase
            end
            if (last) begin
                // A string value cut off by the end of the object still counts as found.
                if (!answered) begin
                    if (phase == PH_VALUE_STR)
                        answer(KIND_FOUND, 1'b0);
                    else
                        answer(KIND_NOT_FOUND, 1'b0);
                end
                clear_parse();
            end
        endfunction

        task report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
            errors++;
            if (errors <= 20)
                $display("Mismatch at result %0d on %s: expected 0x%0h, got 0x%0h",
                         results_checked, what, want_v, got_v);
        endtask

        task check_result(result_item_t got);
            result_item_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", 32'd0, 32'(got));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (got.result_kind !== want.result_kind)
                report_mismatch("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            if (got.value_char !== want.value_char)
                report_mismatch("value_char", 32'(want.value_char), 32'(got.value_char));
            if (got.bool_value !== want.bool_value)
                report_mismatch("bool_value", 32'(want.bool_value), 32'(got.bool_value));
            if (got.final_res !== want.final_res)
                report_mismatch("final_res", 32'(want.final_res), 32'(got.final_res));
            case (want.result_kind)
                KIND_CHAR:  chars_seen++;
                KIND_FOUND: found_seen++;
                default:    missing_seen++;
            endcase
        endtask
    endclass

endpackage

[tb/json_key_value_extractor_test.sv]
// ---------------------------------------------------------------------------
// Testbench for json_key_value_extractor
// Streams JSON objects into the block under several key and mode settings,
// with random gaps and stalls, and checks every result transaction against
// a byte-level prediction held in a scoreboard.
// ---------------------------------------------------------------------------
module json_key_value_extractor_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jkve_pkg::*;
    import jkve_scoreboard_pkg::*;

    // Idle cycles with no transaction on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed for the two-stage pipeline to finish trailing bytes that
    // cause no result, before registers are touched.
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_BYTES   = 700;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  text_valid;
    logic                  text_stall;
    text_item_t            text_item;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_item_t          result_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    extract_scoreboard sb;

    // Register values that the next programming sequence will write. The
    // object generator uses them as well, so that it can aim at the key.
    logic [127:0] key_bits;
    int           key_len;
    bit           bool_mode;
    int           capacity;

    // Bytes of the object being built, and run statistics.
    logic [7:0]   obj_q[$];
    bit           no_gaps;
    int unsigned  stall_left = 0;
    int unsigned  objects_sent;
    int unsigned  bytes_sent;
    int unsigned  settings_used;

    json_key_value_extractor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths: mostly none, some short, a few long. During a steady
    // stretch neither side idles at all.
    function automatic int unsigned draw_gap(int quiet_pct);
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < quiet_pct)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // The result side checks every accepted transaction and stalls at random.
    // Outputs are sampled at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_item);
        if (stall_left != 0) begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else begin
            result_stall <= 1'b0;
            stall_left = rst_n ? draw_gap(80) : 0;
        end
    end

    // Any transaction on any channel counts as progress.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One byte per transaction. Valid is only lowered when a gap is taken,
    // so it is never written twice in the same time step.
    task automatic send_byte(input logic [7:0] b, input bit last);
        text_item_t  item;
        int unsigned gap;
        gap = draw_gap(60);
        if (gap != 0) begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.text_byte = b;
        item.end_of_object = last;
        text_valid <= 1'b1;
        text_item <= item;
        do @(posedge clk); while (text_stall !== 1'b0);
        sb.note_text(item);
    endtask

    task automatic send_object();
        for (int i = 0; i < obj_q.size(); i++)
            send_byte(obj_q[i], i == obj_q.size() - 1);
        objects_sent++;
        bytes_sent += obj_q.size();
    endtask

    // Hold the sender off until every predicted result has been delivered.
    task automatic wait_drained();
        text_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Bytes after an answer cause no result, so the block may still be busy
    // once the queue is empty; give it SETTLE_CYCLES on top.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers in one burst; the block is idle throughout.
    task automatic program_block();
        logic [CFG_DATA_W-1:0] values [5];
        logic [CFG_IDX_W-1:0]  slots [5];
        slots = '{CFG_KEY_LOW, CFG_KEY_HIGH, CFG_KEY_LENGTH, CFG_VALUE_KIND,
                  CFG_OUT_CAPACITY};
        values = '{key_bits[63:0], key_bits[127:64], 64'(key_len), 64'(bool_mode),
                   64'(capacity)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= slots[i];
            cfg_data <= values[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            sb.set_register(slots[i], values[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Object generator
    // ------------------------------------------------------------------

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            obj_q.push_back(s[i]);
    endfunction

    function automatic void add_blanks();
        int n;
        if ($urandom_range(0, 2) != 0)
            return;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       obj_q.push_back(CH_SPACE);
                1:       obj_q.push_back(CH_NEWLINE);
                default: obj_q.push_back(CH_TAB);
            endcase
        end
    endfunction

    // A member name: the configured key itself, or something close to it.
    function automatic void add_key_name(bit hit);
        int n;
        int top;
        int sel;
        top = (key_len < KEY_SLOTS) ? key_len : KEY_SLOTS;
        sel = hit ? 3 : $urandom_range(0, 2);
        obj_q.push_back(CH_QUOTE);
        case (sel)
            0: begin
                n = $urandom_range(0, 4);
                repeat (n) begin
                    if ($urandom_range(0, 6) == 0) begin
                        obj_q.push_back(CH_BACKSLASH);
                        obj_q.push_back(8'($urandom_range(0, 255)));
                    end
                    else begin
                        obj_q.push_back(8'($urandom_range(97, 122)));
                    end
                end
            end
            1: begin
                // A prefix of the key followed by one random letter.
                n = (top == 0) ? 0 : $urandom_range(0, top - 1);
                for (int k = 0; k < n; k++)
                    obj_q.push_back(key_bits[k*8 +: 8]);
                obj_q.push_back(8'($urandom_range(97, 122)));
            end
            2: begin
                for (int k = 0; k < top; k++)
                    obj_q.push_back(key_bits[k*8 +: 8]);
                obj_q.push_back(8'($urandom_range(97, 122)));
            end
            default:
                for (int k = 0; k < top; k++)
                    obj_q.push_back(key_bits[k*8 +: 8]);
        endcase
        obj_q.push_back(CH_QUOTE);
    endfunction

    // String values carry any byte, with escape pairs now and then; a rare
    // long one can reach past the largest output buffer.
    function automatic void add_string_value();
        int         n;
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(0, 6);
        else if (r < 99)
            n = $urandom_range(7, 20);
        else
            n = $urandom_range(250, 262);
        obj_q.push_back(CH_QUOTE);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                obj_q.push_back(CH_BACKSLASH);
                obj_q.push_back(8'($urandom_range(0, 255)));
            end
            else begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BACKSLASH)
                    c = 8'h78;
                obj_q.push_back(c);
            end
        end
        obj_q.push_back(CH_QUOTE);
    endfunction

    // The value of a matching key mostly has the type the mode looks for.
    function automatic void add_value(bit hit);
        int sel;
        sel = $urandom_range(0, 9);
        if (hit && $urandom_range(0, 9) < 7)
            sel = bool_mode ? 3 + $urandom_range(0, 1) : 0;
        case (sel)
            0, 1, 2: add_string_value();
            3:       add_text("true");
            4:       add_text("false");
            5:       if ($urandom_range(0, 1)) add_text("42"); else add_text("-7.5");
            6:
                case ($urandom_range(0, 3))
                    0:       add_text("tru");
                    1:       add_text("fals");
                    2:       add_text("tRue");
                    default: add_text("fx");
                endcase
            7: begin
                // A nested member, which may carry the key one level too deep.
                obj_q.push_back(CH_LBRACE);
                add_key_name($urandom_range(0, 1));
                obj_q.push_back(CH_COLON);
                add_string_value();
                obj_q.push_back(CH_RBRACE);
            end
            8: begin
                obj_q.push_back(CH_LBRACKET);
                add_string_value();
                add_text(",true");
                obj_q.push_back(CH_RBRACKET);
            end
            default: obj_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Mostly well-formed objects; some are preceded by a closing bracket that
    // wraps the depth counter below zero, some are cut short, some are noise.
    function automatic void build_object();
        int  r;
        int  members;
        bit  hit;
        r = $urandom_range(0, 99);
        obj_q.delete();
        if (r < 6) begin
            repeat ($urandom_range(1, 8))
                obj_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (r < 12)
            add_text("}{");
        obj_q.push_back(CH_LBRACE);
        members = $urandom_range(0, 3);
        for (int m = 0; m < members; m++) begin
            add_blanks();
            hit = ($urandom_range(0, 2) == 0);
            add_key_name(hit);
            add_blanks();
            if ($urandom_range(0, 19) != 0)
                obj_q.push_back(CH_COLON);
            add_blanks();
            add_value(hit);
            add_blanks();
            if (m < members - 1)
                obj_q.push_back(8'h2C);
        end
        obj_q.push_back(CH_RBRACE);
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, obj_q.size() - 1))
                void'(obj_q.pop_back());
    endfunction

    function automatic void fill_key(int style);
        logic [7:0] c;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            case (style)
                0: c = 8'($urandom_range(97, 122));
                1: begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || c == CH_BACKSLASH)
                        c = 8'h7A;
                end
                2: c = 8'hFF;
                default: c = 8'h00;
            endcase
            key_bits[k*8 +: 8] = c;
        end
    endfunction

    // The first few settings visit the extremes; later ones are random.
    function automatic void choose_setting(int unsigned n);
        int r;
        case (n)
            0: begin fill_key(2); key_len = 16; bool_mode = 1'b0; capacity = 256; end
            1: begin fill_key(3); key_len = 0;  bool_mode = 1'b1; capacity = 0;   end
            2: begin fill_key(0); key_len = 31; bool_mode = 1'b0; capacity = 1;   end
            3: begin fill_key(1); key_len = 16; bool_mode = 1'b1; capacity = 2;   end
            default: begin
                fill_key($urandom_range(0, 4) == 0 ? 1 : 0);
                r = $urandom_range(0, 9);
                if (r == 0)
                    key_len = 0;
                else if (r == 1)
                    key_len = 16;
                else if (r == 2)
                    key_len = $urandom_range(17, 31);
                else if (r < 5)
                    key_len = $urandom_range(7, 15);
                else
                    key_len = $urandom_range(1, 4);
                bool_mode = $urandom_range(0, 1);
                case ($urandom_range(0, 6))
                    0:       capacity = 0;
                    1:       capacity = 1;
                    2:       capacity = 2;
                    3:       capacity = $urandom_range(3, 8);
                    4:       capacity = $urandom_range(9, 30);
                    5:       capacity = 256;
                    default: capacity = $urandom_range(0, 256);
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned setting_no;
        int unsigned random_start;
        logic [7:0]  edge_bytes [2];

        rst_n = 1'b0;
        text_valid = 1'b0;
        text_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY_LOW;
        cfg_data = '0;
        no_gaps = 1'b0;
        objects_sent = 0;
        bytes_sent = 0;
        settings_used = 0;
        sb = new();
        edge_bytes = '{8'h00, 8'hFF};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the one-byte key "a".
        key_bits = 128'h61;
        key_len = 1;
        bool_mode = 1'b0;
        capacity = 256;
        program_block();
        // A backslash as the last byte of a string value is sent as a character.
        obj_q.delete();
        add_text("{\"a\":\"\\");
        send_object();
        // The object ends before its value starts.
        obj_q.delete();
        add_text("{\"a\":");
        send_object();
        // Single-byte objects with the extreme byte values.
        foreach (edge_bytes[i]) begin
            obj_q.delete();
            obj_q.push_back(edge_bytes[i]);
            send_object();
        end
        settle();
        bool_mode = 1'b1;
        program_block();
        // A complete literal on the final byte, then a literal cut short.
        obj_q.delete();
        add_text("{\"a\":true");
        send_object();
        obj_q.delete();
        add_text("{\"a\":f");
        send_object();

        // Random part: a run of objects under each setting, with the block
        // left idle before every register change.
        random_start = bytes_sent;
        setting_no = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            settle();
            choose_setting(setting_no);
            setting_no++;
            no_gaps = ($urandom_range(0, 3) == 0);
            program_block();
            repeat ($urandom_range(2, 5)) begin
                build_object();
                send_object();
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d objects of %0d bytes in all under %0d register settings.",
                 objects_sent, bytes_sent, settings_used);
        $display("Checked %0d results: %0d characters, %0d found, %0d not found; %0d errors.",
                 sb.results_checked, sb.chars_seen, sb.found_seen, sb.missing_seen,
                 sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
